// ===== sv/mmp_pkg.sv =====
`default_nettype none

package mmp_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QAddrW = 1;

  localparam logic [7:0] HiMask   = 8'hF0;
  localparam logic [7:0] LoMask   = 8'h0F;
  localparam logic [7:0] SysBase  = 8'hF0;
  localparam logic [7:0] RtBase   = 8'hF8;
  localparam logic [7:0] StProg   = 8'hC0;
  localparam logic [7:0] StPress  = 8'hD0;
  localparam logic [7:0] StMtc    = 8'hF1;
  localparam logic [7:0] StSongPos = 8'hF2;
  localparam logic [7:0] StSongSel = 8'hF3;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_RT   = 2'd1,
    KIND_CHAN = 2'd2,
    KIND_SYS  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [1:0]  need;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/mmp_front.sv =====
`default_nettype none

module mmp_front (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output mmp_pkg::item_t     item_o
);

  logic [7:0] hi;

  assign hi         = rx_byte_i & mmp_pkg::HiMask;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.value = rx_byte_i;
    item_o.need  = 2'd0;
    if (!rx_byte_i[7]) begin
      item_o.kind = mmp_pkg::KIND_DATA;
    end else if (rx_byte_i >= mmp_pkg::RtBase) begin
      item_o.kind = mmp_pkg::KIND_RT;
    end else if (rx_byte_i < mmp_pkg::SysBase) begin
      item_o.kind = mmp_pkg::KIND_CHAN;
      item_o.need = (hi == mmp_pkg::StProg || hi == mmp_pkg::StPress) ? 2'd1 : 2'd2;
    end else begin
      item_o.kind = mmp_pkg::KIND_SYS;
      if (rx_byte_i == mmp_pkg::StMtc || rx_byte_i == mmp_pkg::StSongSel) begin
        item_o.need = 2'd1;
      end else if (rx_byte_i == mmp_pkg::StSongPos) begin
        item_o.need = 2'd2;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mmp_queue.sv =====
`default_nettype none

module mmp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mmp_pkg::item_t   item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  nonempty_o,
  output mmp_pkg::item_t        item_o
);

  localparam int unsigned CntW = mmp_pkg::QAddrW + 1;

  mmp_pkg::item_t             slot_q [mmp_pkg::QDepth];
  logic [mmp_pkg::QAddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]            cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(mmp_pkg::QDepth));
  assign nonempty_o = (cnt_q != '0);
  assign item_o     = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == mmp_pkg::QAddrW'(mmp_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == mmp_pkg::QAddrW'(mmp_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mmp_back.sv =====
`default_nettype none

module mmp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_nonempty_i,
  input  wire mmp_pkg::item_t   item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            msg_status_o,
  output logic [3:0]            msg_channel_o,
  output logic                  is_broadcast_o,
  output logic [6:0]            data_first_o,
  output logic [6:0]            data_second_o,
  output logic [1:0]            data_count_o
);

  logic [7:0] status_q, status_d;
  logic [3:0] chan_q, chan_d;
  logic       bcast_q, bcast_d;
  logic [1:0] need_q, need_d;
  logic [1:0] idx_q, idx_d;
  logic [6:0] first_q, first_d;

  logic       ovalid_q, ovalid_d;
  logic [7:0] ostatus_q, ostatus_d;
  logic [3:0] ochan_q, ochan_d;
  logic       obcast_q, obcast_d;
  logic [6:0] od1_q, od1_d;
  logic [6:0] od2_q, od2_d;
  logic [1:0] ocnt_q, ocnt_d;

  logic       emit;
  logic [1:0] idx_inc;

  assign pop_o   = q_nonempty_i && (!ovalid_q || !out_stall_i);
  assign idx_inc = idx_q + 2'd1;

  always_comb begin
    status_d  = status_q;
    chan_d    = chan_q;
    bcast_d   = bcast_q;
    need_d    = need_q;
    idx_d     = idx_q;
    first_d   = first_q;
    emit      = 1'b0;
    ostatus_d = ostatus_q;
    ochan_d   = ochan_q;
    obcast_d  = obcast_q;
    od1_d     = od1_q;
    od2_d     = od2_q;
    ocnt_d    = ocnt_q;
    if (pop_o) begin
      unique case (item_i.kind)
        mmp_pkg::KIND_DATA: begin
          if (need_q != 2'd0) begin
            if (idx_q == 2'd0) begin
              first_d = item_i.value[6:0];
            end
            idx_d = idx_inc;
            if (idx_inc >= need_q) begin
              idx_d     = 2'd0;
              emit      = 1'b1;
              ostatus_d = status_q;
              ochan_d   = chan_q;
              obcast_d  = bcast_q;
              if (need_q == 2'd1) begin
                od1_d  = item_i.value[6:0];
                od2_d  = 7'd0;
                ocnt_d = 2'd1;
              end else begin
                od1_d  = first_q;
                od2_d  = item_i.value[6:0];
                ocnt_d = 2'd2;
              end
            end
          end
        end
        mmp_pkg::KIND_RT: begin
          emit      = 1'b1;
          ostatus_d = item_i.value;
          ochan_d   = 4'd0;
          obcast_d  = 1'b1;
          od1_d     = 7'd0;
          od2_d     = 7'd0;
          ocnt_d    = 2'd0;
        end
        mmp_pkg::KIND_CHAN: begin
          idx_d    = 2'd0;
          status_d = item_i.value & mmp_pkg::HiMask;
          chan_d   = item_i.value[3:0];
          bcast_d  = 1'b0;
          need_d   = item_i.need;
        end
        mmp_pkg::KIND_SYS: begin
          idx_d    = 2'd0;
          status_d = item_i.value;
          chan_d   = 4'd0;
          bcast_d  = 1'b1;
          need_d   = item_i.need;
          if (item_i.need == 2'd0) begin
            emit      = 1'b1;
            ostatus_d = item_i.value;
            ochan_d   = 4'd0;
            obcast_d  = 1'b1;
            od1_d     = 7'd0;
            od2_d     = 7'd0;
            ocnt_d    = 2'd0;
          end
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      chan_q   <= '0;
      bcast_q  <= 1'b0;
      need_q   <= '0;
      idx_q    <= '0;
      first_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      status_q <= status_d;
      chan_q   <= chan_d;
      bcast_q  <= bcast_d;
      need_q   <= need_d;
      idx_q    <= idx_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostatus_q <= ostatus_d;
    ochan_q   <= ochan_d;
    obcast_q  <= obcast_d;
    od1_q     <= od1_d;
    od2_q     <= od2_d;
    ocnt_q    <= ocnt_d;
  end

  assign out_valid_o    = ovalid_q;
  assign msg_status_o   = ostatus_q;
  assign msg_channel_o  = ochan_q;
  assign is_broadcast_o = obcast_q;
  assign data_first_o   = od1_q;
  assign data_second_o  = od2_q;
  assign data_count_o   = ocnt_q;

endmodule

`default_nettype wire

// ===== sv/midi_message_parser.sv =====
// MIDI byte parser with running status.
// A byte that completes a message is written into the two-entry byte queue; the back end
// pops it into the output register, from which the message is transferred.
// Throughput: one byte per cycle while the queue is not full; the back end retires one
// queued byte a cycle unless the output register is full and stalled.
// Reset: asynchronous, clears held status, data index, queue and output valid.
`default_nettype none

module midi_message_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      msg_status_o,
  output logic [3:0]      msg_channel_o,
  output logic            is_broadcast_o,
  output logic [6:0]      data_first_o,
  output logic [6:0]      data_second_o,
  output logic [1:0]      data_count_o
);

  mmp_pkg::item_t push_item, pop_item;
  logic           push, pop, q_full, q_nonempty;

  mmp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  mmp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .nonempty_o (q_nonempty),
    .item_o     (pop_item)
  );

  mmp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_nonempty_i   (q_nonempty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .msg_status_o   (msg_status_o),
    .msg_channel_o  (msg_channel_o),
    .is_broadcast_o (is_broadcast_o),
    .data_first_o   (data_first_o),
    .data_second_o  (data_second_o),
    .data_count_o   (data_count_o)
  );

endmodule

`default_nettype wire
